/* hdl/bilinear_image_sampler_top_macros.svh */
`ifndef BILINEAR_IMAGE_SAMPLER_TOP_MACROS_SVH
`define BILINEAR_IMAGE_SAMPLER_TOP_MACROS_SVH

// same-cycle implication
`define BIS_CHECK_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BIS_CHECK_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/bis_pkg.sv */
`timescale 1ns / 1ps

package bis_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_PIXEL_BITS = 16;
  localparam int DEF_FRAC_BITS  = 16;

  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int COORD_W   = 8;
  localparam int VALUE_W   = 16;
  localparam int SAMPLE_W  = 29;
  localparam int OUT_W     = 16;

  localparam int IN_TDATA_W  = 96;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 16;

  localparam int COL_LSB   = 0;
  localparam int ROW_LSB   = COL_LSB + COORD_W;
  localparam int VALUE_LSB = ROW_LSB + COORD_W;
  localparam int SX_LSB    = VALUE_LSB + VALUE_W;
  localparam int SY_LSB    = SX_LSB + SAMPLE_W;

  localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(256);
  localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(256);

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NORM_MODE    = 2'd2;

  localparam logic [IN_TUSER_W-1:0] OP_WRITE  = 1'b0;
  localparam logic [IN_TUSER_W-1:0] OP_SAMPLE = 1'b1;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SCALE = 7'b0000010,
    ST_LOC   = 7'b0000100,
    ST_READ  = 7'b0001000,
    ST_LERP0 = 7'b0010000,
    ST_LERP1 = 7'b0100000,
    ST_LERP2 = 7'b1000000
  } bis_state_t;

endpackage

/* hdl/bilinear_image_sampler_top.sv */
`timescale 1ns / 1ps

// One-channel bilinear image sampler with clamp-to-edge addressing. A write
// transaction (tuser = 0) stores one pixel in the pixel memory if its column
// and row are in range, and gives no result. A sample transaction (tuser = 1)
// holds the input not ready while it scales the position (in normalized mode),
// locates the neighbours, reads the four neighbours through the one read port
// of the pixel memory, and makes three passes through the shared interpolation
// unit (two along y, one along x); the last pass waits while an earlier result
// is untaken. The result waits in an output register, so a new transaction is
// taken while it is still pending. The pixel memory is not cleared at reset;
// sample only pixels that have been written.

`include "bilinear_image_sampler_top_macros.svh"

module bilinear_image_sampler_top #(
  parameter int MAX_WIDTH  = bis_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bis_pkg::DEF_MAX_HEIGHT,
  parameter int PIXEL_BITS = bis_pkg::DEF_PIXEL_BITS,
  parameter int FRAC_BITS  = bis_pkg::DEF_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // write_col, write_row, write_value, sample_x, sample_y, zero pad
  input  logic [bis_pkg::IN_TDATA_W-1:0]   in_tdata,
  // op
  input  logic [bis_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // sample_value
  output logic [bis_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                             cfg_we,
  input  logic [bis_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bis_pkg::CFG_W-1:0]        cfg_wdata
);

  import bis_pkg::*;

  localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int SZ_W    = $clog2(MAX_DIM + 1);
  localparam int SCL_W   = SAMPLE_W + SZ_W + 1;
  localparam int Q_W     = SCL_W + 1;
  localparam int C_W     = SZ_W + FRAC_BITS;
  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int D_W     = PIXEL_BITS + FRAC_BITS + 3;

  localparam logic signed [Q_W-1:0] HALF_Q = Q_W'(1) <<< (FRAC_BITS - 1);
  localparam logic [FRAC_BITS:0]    ONE_T  = {1'b1, {FRAC_BITS{1'b0}}};

  function automatic logic [SZ_W-1:0] eff_size(input logic [CFG_W-1:0] reg_v,
                                               input int max_v);
    logic [SZ_W-1:0] r;
    if (reg_v == '0) begin
      r = SZ_W'(1);
    end else if (int'(reg_v) > max_v) begin
      r = SZ_W'(max_v);
    end else begin
      r = SZ_W'(reg_v);
    end
    return r;
  endfunction

  bis_state_t state_r, state_nxt;

  logic [CFG_W-1:0] width_r;
  logic [CFG_W-1:0] height_r;
  logic             norm_r;

  logic                       samp_norm_r;
  logic signed [SAMPLE_W-1:0] samp_r [2];
  logic [SZ_W-1:0]            size_r [2];
  logic signed [SCL_W-1:0]    pos_r  [2];
  logic [SZ_W-1:0]            i0_r   [2];
  logic [SZ_W-1:0]            i1_r   [2];
  logic [FRAC_BITS:0]         t_r    [2];

  logic signed [SCL_W-1:0] scaled [2];
  logic signed [Q_W-1:0]   q      [2];
  logic signed [Q_W-1:0]   hi     [2];
  logic [C_W-1:0]          c      [2];
  logic [SZ_W-1:0]         a      [2];
  logic [SZ_W-1:0]         i0_nxt [2];
  logic [SZ_W-1:0]         i1_nxt [2];
  logic [FRAC_BITS:0]      t_nxt  [2];

  logic [PIXEL_BITS-1:0] pix_mem [DEPTH];
  logic [PIXEL_BITS-1:0] rd_data_r;
  logic [PIXEL_BITS-1:0] pix_r [4];
  logic [PIXEL_BITS-1:0] v_r   [2];
  logic [1:0]            rd_cnt_r;
  logic                  rd_pend_r;
  logic [1:0]            rd_idx_r;
  logic [ADDR_W-1:0]     rd_addr;
  logic [SZ_W-1:0]       rd_col;
  logic [SZ_W-1:0]       rd_row;

  logic                  in_fire;
  logic                  mem_we;
  logic [ADDR_W-1:0]     wr_addr;
  logic [COORD_W-1:0]    wr_col;
  logic [COORD_W-1:0]    wr_row;

  logic [PIXEL_BITS-1:0]        lerp_a;
  logic [PIXEL_BITS-1:0]        lerp_b;
  logic [FRAC_BITS:0]           lerp_t;
  logic signed [PIXEL_BITS:0]   lerp_diff;
  logic signed [D_W-1:0]        lerp_prod;
  logic [PIXEL_BITS-1:0]        lerp_res;

  logic                 out_tvalid_r;
  logic [OUT_W-1:0]     out_data_r;
  logic                 out_load;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_load   = (state_r == ST_LERP2) && (!out_tvalid_r || out_tready);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      norm_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
        REG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        REG_NORM_MODE:    norm_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // pixel write path
  assign wr_col  = in_tdata[COL_LSB +: COORD_W];
  assign wr_row  = in_tdata[ROW_LSB +: COORD_W];
  assign wr_addr = ADDR_W'(ADDR_W'(wr_row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(wr_col));
  assign mem_we  = in_fire && (in_tuser == OP_WRITE) &&
                   (int'(wr_col) < MAX_WIDTH) && (int'(wr_row) < MAX_HEIGHT);

  // neighbour read order: (x0,y0) (x0,y1) (x1,y0) (x1,y1)
  assign rd_col  = rd_cnt_r[1] ? i1_r[0] : i0_r[0];
  assign rd_row  = rd_cnt_r[0] ? i1_r[1] : i0_r[1];
  assign rd_addr = ADDR_W'(ADDR_W'(rd_row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(rd_col));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pix_mem[wr_addr] <= PIXEL_BITS'(in_tdata[VALUE_LSB +: VALUE_W]);
    end
    rd_data_r <= pix_mem[rd_addr];
  end

  // coordinate scaling and neighbour location
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      scaled[k] = samp_norm_r ?
                  SCL_W'(samp_r[k]) * SCL_W'(signed'({1'b0, size_r[k]})) :
                  SCL_W'(samp_r[k]);
      q[k]  = Q_W'(pos_r[k]) - HALF_Q;
      hi[k] = signed'(Q_W'({size_r[k], {FRAC_BITS{1'b0}}}));
      if (q[k] < 0) begin
        c[k] = '0;
      end else if (q[k] > hi[k]) begin
        c[k] = C_W'(hi[k]);
      end else begin
        c[k] = C_W'(q[k]);
      end
      a[k] = c[k][C_W-1:FRAC_BITS];
      if (a[k] >= size_r[k]) begin
        i0_nxt[k] = size_r[k] - SZ_W'(1);
        t_nxt[k]  = ONE_T;
      end else begin
        i0_nxt[k] = a[k];
        t_nxt[k]  = {1'b0, c[k][FRAC_BITS-1:0]};
      end
      i1_nxt[k] = (i0_nxt[k] < size_r[k] - SZ_W'(1)) ? i0_nxt[k] + SZ_W'(1) : i0_nxt[k];
    end
  end

  // shared interpolation unit: a + floor((b - a) * t / 2^frac)
  always_comb begin
    case (state_r)
      ST_LERP0: begin
        lerp_a = pix_r[0];
        lerp_b = pix_r[1];
        lerp_t = t_r[1];
      end
      ST_LERP1: begin
        lerp_a = pix_r[2];
        lerp_b = pix_r[3];
        lerp_t = t_r[1];
      end
      default: begin
        lerp_a = v_r[0];
        lerp_b = v_r[1];
        lerp_t = t_r[0];
      end
    endcase
    lerp_diff = signed'({1'b0, lerp_b}) - signed'({1'b0, lerp_a});
    lerp_prod = D_W'(lerp_diff) * D_W'(signed'({1'b0, lerp_t}));
    lerp_res  = PIXEL_BITS'(lerp_prod >>> FRAC_BITS) + lerp_a;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_fire && in_tuser == OP_SAMPLE) state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_LOC;
      ST_LOC:   state_nxt = ST_READ;
      ST_READ:  if (rd_cnt_r == 2'd3) state_nxt = ST_LERP0;
      ST_LERP0: state_nxt = ST_LERP1;
      ST_LERP1: state_nxt = ST_LERP2;
      ST_LERP2: if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rd_cnt_r     <= '0;
      rd_pend_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= (state_r == ST_READ);
      if (state_r == ST_READ) begin
        rd_cnt_r <= rd_cnt_r + 2'd1;
      end else begin
        rd_cnt_r <= '0;
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rd_idx_r <= rd_cnt_r;
    if (rd_pend_r) begin
      pix_r[rd_idx_r] <= rd_data_r;
    end
    if (in_fire) begin
      samp_r[0]   <= in_tdata[SX_LSB +: SAMPLE_W];
      samp_r[1]   <= in_tdata[SY_LSB +: SAMPLE_W];
      size_r[0]   <= eff_size(width_r, MAX_WIDTH);
      size_r[1]   <= eff_size(height_r, MAX_HEIGHT);
      samp_norm_r <= norm_r;
    end
    if (state_r == ST_SCALE) begin
      pos_r[0] <= scaled[0];
      pos_r[1] <= scaled[1];
    end
    if (state_r == ST_LOC) begin
      for (int k = 0; k < 2; k++) begin
        i0_r[k] <= i0_nxt[k];
        i1_r[k] <= i1_nxt[k];
        t_r[k]  <= t_nxt[k];
      end
    end
    if (state_r == ST_LERP0) begin
      v_r[0] <= lerp_res;
    end
    if (state_r == ST_LERP1) begin
      v_r[1] <= lerp_res;
    end
    if (out_load) begin
      out_data_r <= OUT_W'(lerp_res);
    end
  end

  `BIS_CHECK_NEXT(a_result_loaded, out_load, out_tvalid_r && state_r == ST_IDLE, "sample result not loaded")
  `BIS_CHECK_NOW(a_read_in_bounds, state_r == ST_READ, i1_r[0] < size_r[0] && i1_r[1] < size_r[1] && i0_r[0] <= i1_r[0] && i0_r[1] <= i1_r[1], "neighbour index outside image")
  `BIS_CHECK_NEXT(a_last_read_captured, state_r == ST_READ && rd_cnt_r == 2'd3, state_r == ST_LERP0 && rd_pend_r && rd_idx_r == 2'd3, "fourth neighbour read lost")
  `BIS_CHECK_NEXT(a_write_stays_idle, in_fire && in_tuser == OP_WRITE, state_r == ST_IDLE, "pixel write left idle")

endmodule
